>>> rtl/core/ptff_pkg.sv
// Package for the partition table first-fit allocator.
// Holds beat types, status and register codes, controller states and the
// command/status structs shared by the controller, datapath and top level.
package ptff_pkg;

  localparam int SLOT_COUNT = 4;
  localparam int SLOT_W     = 2;
  localparam int CAND_W     = 3;
  localparam int DISK_W     = 31;
  localparam int HDR_W      = 16;

  // The header start plus the end of every slot.
  localparam logic [CAND_W-1:0] LAST_CAND = CAND_W'(SLOT_COUNT);

  localparam logic [1:0] STATUS_CREATED    = 2'd0;
  localparam logic [1:0] STATUS_TABLE_FULL = 2'd1;
  localparam logic [1:0] STATUS_EXT_EXISTS = 2'd2;
  localparam logic [1:0] STATUS_NO_GAP     = 2'd3;

  localparam logic [1:0] CFG_DISK_BYTES   = 2'd0;
  localparam logic [1:0] CFG_HEADER_BYTES = 2'd1;
  localparam logic [1:0] CFG_LINK_BYTES   = 2'd2;

  localparam logic [DISK_W-1:0] DISK_RESET   = '0;
  localparam logic [HDR_W-1:0]  HEADER_RESET = 16'd512;
  localparam logic [HDR_W-1:0]  LINK_RESET   = 16'd32;

  typedef struct packed {
    logic [DISK_W-1:0] request_bytes;
    logic              part_kind;
    logic [1:0]        fit_code;
  } ptff_req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SLOT_W-1:0] slot_index;
    logic [DISK_W-1:0] region_start;
  } ptff_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_JUDGE,
    ST_FINISH
  } ptff_state_t;

  typedef struct packed {
    logic              load;
    logic              eval;
    logic              judge;
    logic              finish;
    logic [CAND_W-1:0] cand;
  } ptff_cmd_t;

  typedef struct packed {
    logic skip;
  } ptff_stat_t;

endpackage

>>> rtl/core/ptff_ctrl.sv
// Controller of the partition table first-fit allocator.
// Steps through the candidate starts; depends on ptff_pkg.
module ptff_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  ptff_pkg::ptff_stat_t stat,
  output ptff_pkg::ptff_cmd_t  cmd
);
  import ptff_pkg::*;

  ptff_state_t       state, state_next;
  logic [CAND_W-1:0] cand, cand_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cand  <= '0;
    end else begin
      state <= state_next;
      cand  <= cand_next;
    end
  end

  always_comb begin
    state_next = state;
    cand_next  = cand;
    unique case (state)
      ST_IDLE: begin
        cand_next = '0;
        if (start) state_next = ST_EVAL;
      end
      ST_EVAL: begin
        if (stat.skip) state_next = ST_FINISH;
        else state_next = ST_JUDGE;
      end
      ST_JUDGE: begin
        if (cand == LAST_CAND) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_EVAL;
          cand_next  = cand + CAND_W'(1);
        end
      end
      ST_FINISH: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.cand = cand;
    busy     = (state != ST_IDLE);
    unique case (state)
      ST_IDLE:   cmd.load   = start;
      ST_EVAL:   cmd.eval   = !stat.skip;
      ST_JUDGE:  cmd.judge  = 1'b1;
      ST_FINISH: cmd.finish = 1'b1;
      default:   cmd        = '0;
    endcase
  end

endmodule

>>> rtl/core/ptff_datapath.sv
// Datapath of the partition table first-fit allocator.
// Holds the configuration, the slot table and the candidate checks; uses ptff_pkg.
module ptff_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr,
  input  logic [1:0]           cfg_index,
  input  logic [30:0]          cfg_data,
  input  ptff_pkg::ptff_req_t  request,
  input  ptff_pkg::ptff_cmd_t  cmd,
  output ptff_pkg::ptff_stat_t stat,
  output logic                 done,
  output ptff_pkg::ptff_rsp_t  result
);
  import ptff_pkg::*;

  logic [DISK_W-1:0] disk_bytes;
  logic [HDR_W-1:0]  header_bytes;
  logic [HDR_W-1:0]  link_bytes;

  logic [SLOT_COUNT-1:0] slot_active;
  logic [SLOT_COUNT-1:0] slot_kind;
  logic [1:0]            slot_fit   [SLOT_COUNT];
  logic [DISK_W-1:0]     slot_start [SLOT_COUNT];
  // Region end (start plus length) is kept instead of the length itself.
  logic [DISK_W:0]       slot_end   [SLOT_COUNT];

  ptff_req_t         req;
  logic              found;
  logic [DISK_W-1:0] best;

  logic [DISK_W:0]   e_pos;
  logic              e_ok;
  logic [DISK_W-1:0] e_end;

  logic              full, has_ext;
  logic [SLOT_W-1:0] free_slot;
  logic [CAND_W-1:0] cand_m1;
  logic [DISK_W:0]   pos;
  logic              cand_valid, in_range, pos_free;
  logic [DISK_W-1:0] run_end;
  logic [DISK_W-1:0] run_len;
  logic              fits;
  logic [1:0]        status_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      disk_bytes   <= DISK_RESET;
      header_bytes <= HEADER_RESET;
      link_bytes   <= LINK_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        CFG_DISK_BYTES:   disk_bytes   <= cfg_data;
        CFG_HEADER_BYTES: header_bytes <= cfg_data[HDR_W-1:0];
        CFG_LINK_BYTES:   link_bytes   <= cfg_data[HDR_W-1:0];
        default:          ;
      endcase
    end
  end

  // Table occupancy and the lowest free slot.
  always_comb begin
    full      = &slot_active;
    has_ext   = |(slot_active & slot_kind);
    free_slot = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!slot_active[i]) free_slot = SLOT_W'(i);
    end
  end

  assign stat.skip = full || (req.part_kind && has_ext) || (req.request_bytes == '0);

  // Candidate evaluation: position, range, freedom and the end of its run.
  always_comb begin
    cand_m1    = cmd.cand - CAND_W'(1);
    cand_valid = (cmd.cand == '0) || slot_active[cand_m1[SLOT_W-1:0]];
    pos        = (cmd.cand == '0) ? (DISK_W + 1)'(header_bytes)
                                  : slot_end[cand_m1[SLOT_W-1:0]];
    in_range   = (pos >= (DISK_W + 1)'(header_bytes)) &&
                 (pos <  {1'b0, disk_bytes});
    pos_free   = 1'b1;
    run_end    = disk_bytes;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (slot_active[i] && (pos >= {1'b0, slot_start[i]}) && (pos < slot_end[i]))
        pos_free = 1'b0;
      if (slot_active[i] && ({1'b0, slot_start[i]} > pos) && (slot_start[i] < run_end))
        run_end = slot_start[i];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      e_pos <= pos;
      e_ok  <= cand_valid && in_range && pos_free;
      e_end <= run_end;
    end
  end

  // A candidate passing the checks lies below the disk end, so it fits 31 bits.
  always_comb begin
    run_len = e_end - e_pos[DISK_W-1:0];
    fits    = e_ok && (run_len >= req.request_bytes) &&
              (!req.part_kind || (run_len > DISK_W'(link_bytes)));
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req   <= request;
      found <= 1'b0;
    end else if (cmd.judge && fits && (!found || (e_pos[DISK_W-1:0] < best))) begin
      found <= 1'b1;
      best  <= e_pos[DISK_W-1:0];
    end
  end

  always_comb begin
    priority if (full)                              status_code = STATUS_TABLE_FULL;
    else if (req.part_kind && has_ext)              status_code = STATUS_EXT_EXISTS;
    else if (!found || (req.request_bytes == '0))   status_code = STATUS_NO_GAP;
    else                                            status_code = STATUS_CREATED;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_active <= '0;
    end else if (cmd.finish && (status_code == STATUS_CREATED)) begin
      slot_active[free_slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && (status_code == STATUS_CREATED)) begin
      slot_kind[free_slot]  <= req.part_kind;
      slot_fit[free_slot]   <= req.fit_code;
      slot_start[free_slot] <= best;
      slot_end[free_slot]   <= {1'b0, best} + {1'b0, req.request_bytes};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= cmd.finish;
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result.status <= status_code;
      if (status_code == STATUS_CREATED) begin
        result.slot_index   <= free_slot;
        result.region_start <= best;
      end else begin
        result.slot_index   <= '0;
        result.region_start <= '0;
      end
    end
  end

endmodule

>>> rtl/core/partition_table_first_fit.sv
// Partition table first-fit allocator, top level.
// The result beat shows on done, registered from the finish state, which
// follows the judge of the last candidate, or the first evaluation when the request errors early.
// A new request is taken only after the previous one finishes (busy is low);
// the scan visits five candidate starts, each with an evaluation and a judge state.
// Reset (rst, synchronous) empties the table and loads the register defaults.
// The receiver cannot stall: each result beat is valid for one cycle only.
module partition_table_first_fit (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr,
  input  logic [1:0]          cfg_index,
  input  logic [30:0]         cfg_data,
  input  logic                start,
  output logic                busy,
  input  ptff_pkg::ptff_req_t request,
  output logic                done,
  output ptff_pkg::ptff_rsp_t result
);
  import ptff_pkg::*;

  // The controller walks the candidate list: the header start first, then
  // the end of every slot. Each candidate has an evaluation state, which
  // finds whether the position is free and where its run ends, and a judge
  // state, which measures the run and keeps the lowest fitting start.
  ptff_cmd_t  cmd;
  ptff_stat_t stat;

  // When the table is full, an extended region already exists or the length
  // is zero, the scan is skipped and the finish cycle reports the error.
  ptff_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // The datapath owns the registers and the slot table. A created region is
  // written into the lowest free slot in the finish cycle, so the next
  // request always sees the updated table.
  ptff_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_wr),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .request   (request),
    .cmd       (cmd),
    .stat      (stat),
    .done      (done),
    .result    (result)
  );

endmodule
